@@ rtl/qesa_pkg.sv @@
// Package for the quadrature encoder speed/angle unit.
// Shared constants, register codes and the configuration struct; no dependencies.
`default_nettype none

package qesa_pkg;

    localparam int COUNT_WIDTH_DEF  = 48;
    localparam int FILTER_WIDTH_DEF = 10;

    localparam int CPR_W    = 16;
    localparam int TPS_W    = 27;
    localparam int GLITCH_W = 10;
    localparam int CFG_W    = 27;
    localparam int TICK_W   = 32;
    localparam int MUL_W    = 32;
    localparam int DEN_W    = 68;
    localparam int ANG_W    = 64;
    localparam int WRAP_W   = 19;
    localparam int VEL_W    = 32;

    localparam logic [1:0] CFG_CPR    = 2'd0;
    localparam logic [1:0] CFG_TPS    = 2'd1;
    localparam logic [1:0] CFG_GLITCH = 2'd2;

    localparam logic [CPR_W-1:0]    CPR_RESET    = 16'd2400;
    localparam logic [TPS_W-1:0]    TPS_RESET    = 27'd1000000;
    localparam logic [GLITCH_W-1:0] GLITCH_RESET = 10'd1;

    localparam logic [MUL_W-1:0] MDEG_PER_REV = 32'd360000;
    localparam logic [MUL_W-1:0] PI_NANO      = 32'd3141592653;
    localparam logic [MUL_W-1:0] MICRO        = 32'd1000000;

    typedef struct packed {
        logic [CPR_W-1:0]    cpr;
        logic [TPS_W-1:0]    tps;
        logic [GLITCH_W-1:0] glitch;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/qesa_fifo.sv @@
// Two-entry request queue between front and back.
// Depends on nothing but its data width parameter.
`default_nettype none

module qesa_fifo #(
    parameter int DATA_W = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_push_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_push_data;
    end

endmodule

`default_nettype wire

@@ rtl/qesa_front.sv @@
// Front end: pin glitch filters, x4 counter, tick counter and read snapshot.
// Depends on qesa_pkg; pushes read requests into qesa_fifo.
`default_nettype none

module qesa_front
    import qesa_pkg::*;
#(
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int FILTER_WIDTH = FILTER_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_pin_a,
    input  wire logic                          i_pin_b,
    input  wire logic                          i_read_now,
    output logic                               o_in_stall,
    input  wire t_cfg                          i_cfg,
    input  wire logic                          i_full,
    output logic                               o_push,
    output logic [2*COUNT_WIDTH+TICK_W-1:0]    o_push_data
);

    localparam int LW = 17;
    localparam logic [LW-1:0] FILT_MAX = LW'((1 << FILTER_WIDTH) - 1);

    logic                    r_lvl [2];
    logic [FILTER_WIDTH-1:0] r_stab [2];
    logic [COUNT_WIDTH-1:0]  r_total;
    logic [COUNT_WIDTH-1:0]  r_last;
    logic [TICK_W-1:0]       r_ticks;
    logic                    r_seen;

    logic                    n_lvl [2];
    logic [FILTER_WIDTH-1:0] n_stab [2];
    logic                    chg [2];
    logic [COUNT_WIDTH-1:0]  n_total;
    logic [TICK_W-1:0]       ticks_inc;
    logic [TICK_W-1:0]       dt;
    logic [LW-1:0]           lim;
    logic [LW-1:0]           c;
    logic                    raw;
    logic                    accept;

    assign accept     = i_in_valid && !i_full;
    assign o_in_stall = i_full;

    always_comb begin
        lim = ({7'd0, i_cfg.glitch} > FILT_MAX) ? FILT_MAX : {7'd0, i_cfg.glitch};
        for (int p = 0; p < 2; p++) begin
            raw = (p == 0) ? i_pin_a : i_pin_b;
            c = LW'(r_stab[p]) + LW'(1);
            n_lvl[p]  = r_lvl[p];
            n_stab[p] = r_stab[p];
            chg[p]    = 1'b0;
            if (raw == r_lvl[p]) begin
                n_stab[p] = '0;
            end else if (c > lim) begin
                n_lvl[p]  = raw;
                n_stab[p] = '0;
                chg[p]    = 1'b1;
            end else begin
                n_stab[p] = c[FILTER_WIDTH-1:0];
            end
        end
        n_total = r_total;
        if (chg[0] && !chg[1]) begin
            n_total = (n_lvl[0] != n_lvl[1]) ? r_total + COUNT_WIDTH'(1)
                                             : r_total - COUNT_WIDTH'(1);
        end else if (chg[1] && !chg[0]) begin
            n_total = (n_lvl[1] == n_lvl[0]) ? r_total + COUNT_WIDTH'(1)
                                             : r_total - COUNT_WIDTH'(1);
        end
        ticks_inc = (&r_ticks) ? r_ticks : r_ticks + TICK_W'(1);
        dt = (r_seen && ticks_inc != '0) ? ticks_inc : {5'd0, i_cfg.tps};
    end

    assign o_push      = accept && i_read_now;
    assign o_push_data = {n_total, n_total - r_last, dt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 2; p++) begin
                r_lvl[p]  <= 1'b0;
                r_stab[p] <= '0;
            end
            r_total <= '0;
            r_last  <= '0;
            r_ticks <= '0;
            r_seen  <= 1'b0;
        end else if (accept) begin
            for (int p = 0; p < 2; p++) begin
                r_lvl[p]  <= n_lvl[p];
                r_stab[p] <= n_stab[p];
            end
            r_total <= n_total;
            if (i_read_now) begin
                r_last  <= n_total;
                r_ticks <= '0;
                r_seen  <= 1'b1;
            end else begin
                r_ticks <= ticks_inc;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/qesa_back.sv @@
// Back end: serial shift-add multiplier and restoring divider that turn a read
// snapshot into angles and velocity. Depends on qesa_pkg; pops qesa_fifo.
`default_nettype none

module qesa_back
    import qesa_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire t_cfg                              i_cfg,
    input  wire logic                              i_ent_valid,
    input  wire logic [2*COUNT_WIDTH+TICK_W-1:0]   i_ent_data,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [COUNT_WIDTH-1:0]          o_position_count,
    output logic signed [ANG_W-1:0]                o_angle_accum_mdeg,
    output logic [WRAP_W-1:0]                      o_angle_wrapped_mdeg,
    output logic signed [VEL_W-1:0]                o_velocity_mrad_s
);

    localparam int W    = COUNT_WIDTH + 60;
    localparam int RW   = DEN_W + 1;
    localparam int CNTW = $clog2(W + 1);

    localparam logic [3:0] S_ACC_MUL = 4'd0;
    localparam logic [3:0] S_ACC_DIV = 4'd1;
    localparam logic [3:0] S_REM     = 4'd2;
    localparam logic [3:0] S_WR_MUL  = 4'd3;
    localparam logic [3:0] S_WR_DIV  = 4'd4;
    localparam logic [3:0] S_DEN_DT  = 4'd5;
    localparam logic [3:0] S_DEN_US  = 4'd6;
    localparam logic [3:0] S_VEL_PI  = 4'd7;
    localparam logic [3:0] S_VEL_TPS = 4'd8;
    localparam logic [3:0] S_VEL_DIV = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    localparam logic [W-1:0] ANG_MAG_MIN = W'(1) << (ANG_W - 1);
    localparam logic [W-1:0] VEL_MAG_MIN = W'(1) << (VEL_W - 1);

    logic [3:0]       r_step;
    logic             r_busy;
    logic [CNTW-1:0]  r_cnt;
    logic             r_out_valid;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_aux;
    logic [MUL_W-1:0] r_mul;
    logic [RW-1:0]    r_rem;
    logic [DEN_W-1:0] r_den;
    logic [W-1:0]     r_qa;
    logic [WRAP_W-1:0] r_wrap;

    logic [COUNT_WIDTH-1:0] ent_count;
    logic [COUNT_WIDTH-1:0] ent_delta;
    logic [TICK_W-1:0]      ent_dt;
    logic                   neg_c;
    logic                   neg_d;
    logic [COUNT_WIDTH-1:0] mag_c;
    logic [COUNT_WIDTH-1:0] mag_d;
    logic [CPR_W-1:0]       rem16;
    logic [CPR_W-1:0]       rprime;
    logic                   is_div;
    logic [W-1:0]           src;
    logic [MUL_W-1:0]       mul_b;
    logic [DEN_W-1:0]       divisor;
    logic [RW-1:0]          rem_t;
    logic                   ge;
    logic [RW-1:0]          n_rem;
    logic [W-1:0]           n_aux;
    logic [W-1:0]           n_acc;
    logic                   last;
    logic                   start;
    logic                   out_free;
    logic                   out_load;
    logic [ANG_W-1:0]       ang_sat;
    logic [VEL_W-1:0]       vel_sat;

    assign ent_count = i_ent_data[2*COUNT_WIDTH+TICK_W-1 -: COUNT_WIDTH];
    assign ent_delta = i_ent_data[COUNT_WIDTH+TICK_W-1 -: COUNT_WIDTH];
    assign ent_dt    = i_ent_data[TICK_W-1:0];
    assign neg_c     = ent_count[COUNT_WIDTH-1];
    assign neg_d     = ent_delta[COUNT_WIDTH-1];
    assign mag_c     = neg_c ? ~ent_count + COUNT_WIDTH'(1) : ent_count;
    assign mag_d     = neg_d ? ~ent_delta + COUNT_WIDTH'(1) : ent_delta;
    assign rem16     = r_rem[CPR_W-1:0];
    assign rprime    = (neg_c && rem16 != '0) ? i_cfg.cpr - rem16 : rem16;

    assign is_div = (r_step == S_ACC_DIV) || (r_step == S_REM) ||
                    (r_step == S_WR_DIV) || (r_step == S_VEL_DIV);
    assign last     = r_busy && (r_cnt == CNTW'(1));
    assign start    = !r_busy && (r_step != S_OUT) &&
                      (r_step != S_ACC_MUL || i_ent_valid);
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = !r_busy && (r_step == S_OUT) && out_free;
    assign o_pop    = out_load;
    assign o_out_valid = r_out_valid;

    always_comb begin
        case (r_step)
            S_ACC_MUL, S_REM: src = {{(W-COUNT_WIDTH){1'b0}}, mag_c};
            S_WR_MUL:         src = {{(W-CPR_W){1'b0}}, rprime};
            S_DEN_DT:         src = {{(W-CPR_W){1'b0}}, i_cfg.cpr};
            S_VEL_PI:         src = {{(W-COUNT_WIDTH){1'b0}}, mag_d};
            default:          src = r_acc;
        endcase
        case (r_step)
            S_ACC_MUL, S_WR_MUL: mul_b = MDEG_PER_REV;
            S_DEN_DT:            mul_b = ent_dt;
            S_DEN_US:            mul_b = MICRO;
            S_VEL_PI:            mul_b = PI_NANO;
            S_VEL_TPS:           mul_b = {4'd0, i_cfg.tps, 1'b0};
            default:             mul_b = '0;
        endcase
        divisor = (r_step == S_VEL_DIV) ? r_den : {{(DEN_W-CPR_W){1'b0}}, i_cfg.cpr};
        rem_t = {r_rem[RW-2:0], r_aux[W-1]};
        ge    = rem_t >= {1'b0, divisor};
        n_rem = ge ? rem_t - {1'b0, divisor} : rem_t;
        n_aux = {r_aux[W-2:0], ge};
        n_acc = r_mul[0] ? r_acc + r_aux : r_acc;

        if (neg_c) begin
            ang_sat = (r_qa > ANG_MAG_MIN) ? {1'b1, {(ANG_W-1){1'b0}}}
                                           : ~r_qa[ANG_W-1:0] + ANG_W'(1);
        end else begin
            ang_sat = (r_qa > ANG_MAG_MIN - W'(1)) ? {1'b0, {(ANG_W-1){1'b1}}}
                                                    : r_qa[ANG_W-1:0];
        end
        if (neg_d) begin
            vel_sat = (r_acc > VEL_MAG_MIN) ? {1'b1, {(VEL_W-1){1'b0}}}
                                            : ~r_acc[VEL_W-1:0] + VEL_W'(1);
        end else begin
            vel_sat = (r_acc > VEL_MAG_MIN - W'(1)) ? {1'b0, {(VEL_W-1){1'b1}}}
                                                     : r_acc[VEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_ACC_MUL;
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load)          r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (last) begin
                    r_busy <= 1'b0;
                    r_step <= r_step + 4'd1;
                end
            end else if (out_load) begin
                r_step <= S_ACC_MUL;
            end else if (start) begin
                r_busy <= 1'b1;
                r_cnt  <= is_div ? CNTW'(W) : CNTW'(MUL_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_aux <= src;
            r_mul <= mul_b;
            if (is_div) r_rem <= '0;
            else        r_acc <= '0;
        end else if (r_busy) begin
            if (is_div) begin
                r_aux <= n_aux;
                r_rem <= n_rem;
                if (last) begin
                    r_acc <= n_aux;
                    if (r_step == S_ACC_DIV) r_qa   <= n_aux;
                    if (r_step == S_WR_DIV)  r_wrap <= n_aux[WRAP_W-1:0];
                end
            end else begin
                r_acc <= n_acc;
                r_aux <= {r_aux[W-2:0], 1'b0};
                r_mul <= {1'b0, r_mul[MUL_W-1:1]};
                if (last && r_step == S_DEN_US) r_den <= n_acc[DEN_W-1:0];
            end
        end
        if (out_load) begin
            o_position_count     <= ent_count;
            o_angle_accum_mdeg   <= ang_sat;
            o_angle_wrapped_mdeg <= r_wrap;
            o_velocity_mrad_s    <= vel_sat;
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= S_OUT) else $error("sequencer step out of range");
    a_no_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step != S_OUT) else $error("serial unit busy at output step");
    a_entry_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy || r_step != S_ACC_MUL) |-> i_ent_valid)
        else $error("request left queue while in work");
`endif

endmodule

`default_nettype wire

@@ rtl/quadrature_encoder_speed_angle_unit.sv @@
// Top level of the quadrature encoder speed/angle unit: configuration
// registers, front end, request queue and back end. Depends on qesa_pkg.
`default_nettype none

// Pin samples are taken one per cycle while the input is not stalled, and counted
// at once. A read request is snapshotted and queued (two deep); the back end works
// it out on one shared serial multiply/divide unit. Only with two reads queued
// does the input stall.

module quadrature_encoder_speed_angle_unit
    import qesa_pkg::*;
#(
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int FILTER_WIDTH = FILTER_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_pin_a,
    input  wire logic                      i_pin_b,
    input  wire logic                      i_read_now,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [COUNT_WIDTH-1:0]  o_position_count,
    output logic signed [ANG_W-1:0]        o_angle_accum_mdeg,
    output logic [WRAP_W-1:0]              o_angle_wrapped_mdeg,
    output logic signed [VEL_W-1:0]        o_velocity_mrad_s,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [CFG_W-1:0]          i_cfg_data
);

    localparam int ENT_W = 2*COUNT_WIDTH + TICK_W;

    logic [CPR_W-1:0]    r_cpr;
    logic [TPS_W-1:0]    r_tps;
    logic [GLITCH_W-1:0] r_glitch;
    t_cfg                cfg;
    logic                push;
    logic [ENT_W-1:0]    push_data;
    logic                full;
    logic                pop;
    logic                ent_valid;
    logic [ENT_W-1:0]    ent_data;

    assign o_cfg_ready = 1'b1;
    assign cfg.cpr    = (r_cpr == '0) ? CPR_W'(1) : r_cpr;
    assign cfg.tps    = (r_tps == '0) ? TPS_W'(1) : r_tps;
    assign cfg.glitch = r_glitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr    <= CPR_RESET;
            r_tps    <= TPS_RESET;
            r_glitch <= GLITCH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CPR:    r_cpr    <= i_cfg_data[CPR_W-1:0];
                CFG_TPS:    r_tps    <= i_cfg_data[TPS_W-1:0];
                CFG_GLITCH: r_glitch <= i_cfg_data[GLITCH_W-1:0];
                default:    ;
            endcase
        end
    end

    qesa_front #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .FILTER_WIDTH (FILTER_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_pin_a     (i_pin_a),
        .i_pin_b     (i_pin_b),
        .i_read_now  (i_read_now),
        .o_in_stall  (o_in_stall),
        .i_cfg       (cfg),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    qesa_fifo #(
        .DATA_W (ENT_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_full      (full),
        .o_valid     (ent_valid),
        .o_data      (ent_data)
    );

    qesa_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (cfg),
        .i_ent_valid          (ent_valid),
        .i_ent_data           (ent_data),
        .o_pop                (pop),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_position_count     (o_position_count),
        .o_angle_accum_mdeg   (o_angle_accum_mdeg),
        .o_angle_wrapped_mdeg (o_angle_wrapped_mdeg),
        .o_velocity_mrad_s    (o_velocity_mrad_s)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for quadrature_encoder_speed_angle_unit.
// Drives pin samples, read requests and register writes; a scoreboard class predicts
// every readout. Depends on qesa_pkg and the unit itself.
module tb;
    import qesa_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 700;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [47:0] pos;
        logic [63:0] ang;
        logic [18:0] wrap;
        logic [31:0] vel;
    } t_readout;

    class encoder_scoreboard;
        t_readout pending[$];
        bit [1:0] filt;
        int unsigned stab[2];
        logic [47:0] total;
        logic [47:0] last_total;
        logic [31:0] ticks;
        bit seen;
        int unsigned cpr;
        int unsigned tps;
        int unsigned glitch;
        int unsigned errors;
        int unsigned reads;
        int unsigned items;

        function new();
            filt = 0;
            stab[0] = 0;
            stab[1] = 0;
            total = 0;
            last_total = 0;
            ticks = 0;
            seen = 0;
            cpr = CPR_RESET;
            tps = TPS_RESET;
            glitch = GLITCH_RESET;
            errors = 0;
            reads = 0;
            items = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_CPR: cpr = data[CPR_W-1:0];
                CFG_TPS: tps = data[TPS_W-1:0];
                CFG_GLITCH: glitch = data[GLITCH_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [47:0] magnitude(logic [47:0] v);
            return v[47] ? -v : v;
        endfunction

        function void note_input(bit a, bit b, bit rd);
            bit [1:0] raw;
            bit [1:0] chg;
            int unsigned c;
            logic [127:0] cpr_w, tps_w, dt_w, m, q, r;
            logic [47:0] delta;
            bit neg;
            t_readout exp_r;
            raw = {b, a};
            chg = 0;
            items++;
            cpr_w = (cpr == 0) ? 128'd1 : 128'(cpr);
            tps_w = (tps == 0) ? 128'd1 : 128'(tps);
            for (int p = 0; p < 2; p++) begin
                if (raw[p] == filt[p]) begin
                    stab[p] = 0;
                end else begin
                    c = stab[p] + 1;
                    if (c > glitch) begin
                        filt[p] = raw[p];
                        stab[p] = 0;
                        chg[p] = 1;
                    end else begin
                        stab[p] = c;
                    end
                end
            end
            if (chg == 2'b01)
                total = (filt[0] != filt[1]) ? total + 48'd1 : total - 48'd1;
            else if (chg == 2'b10)
                total = (filt[1] == filt[0]) ? total + 48'd1 : total - 48'd1;
            if (ticks != 32'hFFFF_FFFF)
                ticks++;
            if (!rd)
                return;

            neg = total[47];
            m = 128'(magnitude(total));
            q = m * 128'd360000 / cpr_w;
            if (neg)
                exp_r.ang = (q > 128'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
                                                            : -q[63:0];
            else
                exp_r.ang = (q > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                            : q[63:0];
            r = m % cpr_w;
            if (neg && r != 0)
                r = cpr_w - r;
            q = r * 128'd360000 / cpr_w;
            exp_r.wrap = q[18:0];

            dt_w = (seen && ticks != 0) ? 128'(ticks) : tps_w;
            delta = total - last_total;
            neg = delta[47];
            m = 128'(magnitude(delta));
            q = m * 128'(PI_NANO) * (128'd2 * tps_w) / cpr_w / dt_w / 128'(MICRO);
            if (neg)
                exp_r.vel = (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
            else
                exp_r.vel = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
            exp_r.pos = total;
            pending.push_back(exp_r);
            last_total = total;
            ticks = 0;
            seen = 1;
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check(t_readout act);
            t_readout exp_r;
            if (pending.size() == 0) begin
                fail($sformatf("readout with none pending: %h", act));
                return;
            end
            exp_r = pending.pop_front();
            reads++;
            if (act.pos !== exp_r.pos)
                fail($sformatf("position exp %0d got %0d", $signed(exp_r.pos), $signed(act.pos)));
            if (act.ang !== exp_r.ang)
                fail($sformatf("angle exp %0d got %0d", $signed(exp_r.ang), $signed(act.ang)));
            if (act.wrap !== exp_r.wrap)
                fail($sformatf("wrapped exp %0d got %0d", exp_r.wrap, act.wrap));
            if (act.vel !== exp_r.vel)
                fail($sformatf("velocity exp %0d got %0d", $signed(exp_r.vel), $signed(act.vel)));
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic i_pin_a = 0;
    logic i_pin_b = 0;
    logic i_read_now = 0;
    logic i_out_stall = 0;
    logic i_cfg_valid = 0;
    logic [1:0] i_cfg_index = 0;
    logic [CFG_W-1:0] i_cfg_data = 0;
    logic o_in_stall;
    logic o_out_valid;
    logic o_cfg_ready;
    logic signed [47:0] o_position_count;
    logic signed [63:0] o_angle_accum_mdeg;
    logic [18:0] o_angle_wrapped_mdeg;
    logic signed [31:0] o_velocity_mrad_s;

    encoder_scoreboard sb = new();
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned phases = 0;
    bit [1:0] quad_step = 0;

    quadrature_encoder_speed_angle_unit i_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            sb.check({o_position_count, o_angle_accum_mdeg, o_angle_wrapped_mdeg,
                      o_velocity_mrad_s});
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    // readout side back-pressure
    always @(posedge i_clk) begin
        int unsigned r;
        if (stall_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                i_out_stall <= 0;
                stall_left <= $urandom_range(1, 40);
            end else if (r < 90) begin
                i_out_stall <= 1;
                stall_left <= $urandom_range(1, 4);
            end else begin
                i_out_stall <= 1;
                stall_left <= $urandom_range(20, 80);
            end
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    task automatic send(bit a, bit b, bit rd);
        int unsigned r;
        int unsigned gap;
        r = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_pin_a <= a;
        i_pin_b <= b;
        i_read_now <= rd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(a, b, rd);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        sb.write_reg(idx, data);
    endtask

    task automatic settle();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic bit [1:0] gray_pins(bit [1:0] s);
        case (s)
            2'd0: return 2'b00;
            2'd1: return 2'b01;
            2'd2: return 2'b11;
            default: return 2'b10;
        endcase
    endfunction

    // mostly clean quadrature motion held past the filter, some noise bursts
    task automatic random_motion(int unsigned n);
        int unsigned sent;
        int unsigned hold;
        bit up;
        bit [1:0] ab;
        sent = 0;
        up = 1'($urandom_range(0, 1));
        while (sent < n) begin
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 99) < 20)
                    up = !up;
                quad_step = up ? quad_step + 2'd1 : quad_step - 2'd1;
                ab = gray_pins(quad_step);
                hold = sb.glitch + 1 + $urandom_range(0, 3);
                repeat (hold) begin
                    if (sent < n) begin
                        send(ab[0], ab[1], $urandom_range(0, 19) == 0);
                        sent++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 19) == 0);
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(int unsigned cpr, int unsigned tps, int unsigned glitch,
                             int unsigned n);
        settle();
        write_reg(CFG_CPR, CFG_W'(cpr));
        write_reg(CFG_TPS, CFG_W'(tps));
        write_reg(CFG_GLITCH, CFG_W'(glitch));
        phases++;
        random_motion(n);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // first read, clean up/down steps, both pins at once, short pulse,
        // back-to-back reads
        send(0, 0, 1);
        send(1, 0, 0); send(1, 0, 0);
        send(1, 1, 0); send(1, 1, 0);
        send(0, 1, 0); send(0, 1, 1);
        send(0, 0, 0); send(0, 0, 1);
        send(0, 1, 0); send(0, 1, 0);
        send(1, 1, 0); send(1, 1, 1);
        send(0, 0, 0); send(0, 0, 1);
        send(1, 1, 1);
        send(1, 0, 0); send(1, 0, 1);
        send(0, 0, 0); send(0, 0, 1); send(0, 0, 1);

        settle();
        write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 2 ** CFG_W - 1)));
        run_phase(4, 1, 0, 250);
        run_phase(65535, 100000000, 3, 250);
        run_phase(4, 100000000, 0, 250);
        run_phase(0, 0, 0, 200);
        run_phase($urandom_range(4, 65535), $urandom_range(1, 100000000),
                  $urandom_range(0, 7), 480);
        run_phase(360, 1000, 1023, 150);
        run_phase(2400 | (32'h7FF << 16), $urandom_range(1, 1000), 1, 200);

        settle();
        if (sb.pending.size() != 0)
            sb.fail($sformatf("%0d readouts never arrived", sb.pending.size()));
        $display("%0d samples over %0d register settings, %0d readouts checked",
                 sb.items, phases + 1, sb.reads);
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/qesa_pkg.sv
rtl/qesa_fifo.sv
rtl/qesa_front.sv
rtl/qesa_back.sv
rtl/quadrature_encoder_speed_angle_unit.sv
tb/sv/tb.sv
